### rtl/dfim_pkg.sv
`timescale 1ns / 1ps
package dfim_pkg;

	// operation codes carried in the input tuser
	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	// status codes carried in the output tuser
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NO_SAMP = 2'd2;

	localparam int VEL_W  = 10;
	localparam int DIM_W  = 12;
	localparam int WT_W   = 17;
	localparam int SQ_IN_W  = 32;
	localparam int SQ_OUT_W = 16;
	localparam int SQ_STEPS = 16;
	localparam int MIN_WSUM = 7;
	localparam logic [WT_W-1:0] WT_ONE = 17'h1_0000;
	localparam logic [15:0] RATIO_MAX = 16'hFFFF;

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_RDW, S_DOT1, S_DOT2, S_CR1, S_CR2, S_DX, S_DY,
		S_WGO, S_WDIV, S_SQ, S_ACC1, S_ACC2, S_ACC3, S_FCHK, S_FW, S_FH,
		S_AREA1, S_AREA2, S_RGO, S_RDIV, S_DONE
	} dfim_state_t;

endpackage

### rtl/direction_filtered_idw_size_mean_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tuser: func; tdata: pos, vel, size
// m_axis    out  m_axis_tvalid/tready    tuser: status; tdata: means, area, ratio
//
// add, clear and the unused code pass through S_DONE and return to ready
// a query walks every stored entry, using one shared divider and one root unit:
// a motionless entry is skipped when the query moves, one failing the direction test
// is skipped, a kept entry takes a divide and a root when its distance is above one;
// the tail divides both means if sum_w reaches MIN_WSUM, the ratio if mean area > 0
// reset clears count, sequencer and output valid; the input is ready only when idle
module direction_filtered_idw_size_mean_top #(
	parameter int TABLE_DEPTH = 256,
	parameter int COORD_BITS  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pos_x[11:0] pos_y[23:12] vel_x[33:24] vel_y[43:34] obj_width[55:44]
	// obj_height[67:56], zero fill
	input  logic [71:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// mean_width[11:0] mean_height[23:12] mean_area[47:24] area_ratio[63:48]
	output logic [63:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]  m_axis_tuser
);
	localparam int VW   = dfim_pkg::VEL_W;
	localparam int DMW  = dfim_pkg::DIM_W;
	localparam int CB   = COORD_BITS;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PW   = 2 * CB;
	localparam int EW   = PW + 2 * VW + 2 * DMW;
	localparam int D2W  = 2 * CB + 1;
	localparam int WSW  = dfim_pkg::WT_W + CW;
	localparam int PSW  = dfim_pkg::WT_W + DMW + CW;
	localparam int NUMW = (PSW > 33) ? PSW : 33;
	localparam int DM1  = (D2W > WSW) ? D2W : WSW;
	localparam int DENW = (DM1 > 24) ? DM1 : 24;

	dfim_pkg::dfim_state_t state_q, state_d;

	// input fields
	logic [1:0]     func;
	logic [CB-1:0]  in_px, in_py;
	logic [VW-1:0]  in_vx, in_vy;
	logic [DMW-1:0] in_w, in_h;
	logic           acc;

	assign func  = s_axis_tuser;
	assign in_px = CB'(s_axis_tdata[11:0]);
	assign in_py = CB'(s_axis_tdata[23:12]);
	assign in_vx = s_axis_tdata[33:24];
	assign in_vy = s_axis_tdata[43:34];
	assign in_w  = s_axis_tdata[55:44];
	assign in_h  = s_axis_tdata[67:56];
	assign acc   = s_axis_tvalid && s_axis_tready;

	// control
	logic [CW-1:0] count_q, idx_q;
	logic          m_valid_q;

	// query and walk registers
	logic [CB-1:0]       qx_q, qy_q;
	logic signed [VW-1:0] qvx_q, qvy_q;
	logic [DMW-1:0]      qw_q, qh_q;
	logic                use_dir_q;
	logic [EW-1:0]       ent_q;
	logic signed [2*VW:0]   p_q, dot_q;
	logic [2*CB-1:0]     sq_q;
	logic [D2W-1:0]      d2_q;
	logic [dfim_pkg::WT_W-1:0] wt_q;
	logic [dfim_pkg::WT_W+DMW-1:0] p2_q;
	logic [WSW-1:0]      sum_w_q;
	logic [PSW-1:0]      sum_ww_q, sum_wh_q;
	logic [DMW-1:0]      mw_q, mh_q;
	logic [2*DMW-1:0]    marea_q, cur_q;
	logic [15:0]         ratio_q;
	logic [1:0]          status_q;

	// entry fields
	logic [CB-1:0]        ex_pos, ey_pos;
	logic signed [VW-1:0] evx, evy;
	logic [DMW-1:0]       ew, eh;

	assign ex_pos = ent_q[CB-1:0];
	assign ey_pos = ent_q[PW-1:CB];
	assign evx    = ent_q[PW+VW-1:PW];
	assign evy    = ent_q[PW+2*VW-1:PW+VW];
	assign ew     = ent_q[PW+2*VW+DMW-1:PW+2*VW];
	assign eh     = ent_q[EW-1:PW+2*VW+DMW];

	// entry table
	logic          ram_we;
	logic [EW-1:0] ram_wdata, ram_rdata;

	assign ram_we    = acc && func == dfim_pkg::FUNC_ADD
		&& count_q < CW'(TABLE_DEPTH);
	assign ram_wdata = {in_h, in_w, in_vy, in_vx, in_py, in_px};

	dfim_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// shared divider and root unit
	logic            div_start, div_busy, div_done;
	logic [NUMW-1:0] div_num, div_quo;
	logic [DENW-1:0] div_den;
	logic            sq_start, sq_done;
	logic [dfim_pkg::SQ_OUT_W-1:0] sq_root;

	dfim_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	dfim_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (div_quo[dfim_pkg::SQ_IN_W-1:0]),
		.done   (sq_done),
		.root   (sq_root)
	);

	// direction test helpers
	logic signed [2*VW-1:0] mul_a;
	logic signed [2*VW+1:0] cross_v;
	logic [2*VW+1:0]        cross_abs;
	logic [CB-1:0]          adx, ady;

	always_comb begin
		mul_a     = qvy_q * evx;
		cross_v   = (2*VW+2)'(p_q) - (2*VW+2)'(mul_a);
		cross_abs = cross_v[2*VW+1] ? (2*VW+2)'(-cross_v) : cross_v;
		adx       = (qx_q >= ex_pos) ? qx_q - ex_pos : ex_pos - qx_q;
		ady       = (qy_q >= ey_pos) ? qy_q - ey_pos : ey_pos - qy_q;
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		sq_start  = 1'b0;
		div_num   = NUMW'(sum_ww_q);
		div_den   = DENW'(sum_w_q);
		case (state_q)
			dfim_pkg::S_IDLE: begin
				if (acc) begin
					state_d = (func == dfim_pkg::FUNC_QUERY) ? dfim_pkg::S_RD
						: dfim_pkg::S_DONE;
				end
			end
			dfim_pkg::S_RD: begin
				state_d = (idx_q == count_q) ? dfim_pkg::S_FCHK : dfim_pkg::S_RDW;
			end
			dfim_pkg::S_RDW: begin
				if (!use_dir_q) begin
					state_d = dfim_pkg::S_DX;
				end else if (ram_rdata[PW+2*VW-1:PW] == '0) begin
					state_d = dfim_pkg::S_RD;
				end else begin
					state_d = dfim_pkg::S_DOT1;
				end
			end
			dfim_pkg::S_DOT1: state_d = dfim_pkg::S_DOT2;
			dfim_pkg::S_DOT2: state_d = dfim_pkg::S_CR1;
			dfim_pkg::S_CR1:  state_d = dfim_pkg::S_CR2;
			dfim_pkg::S_CR2: begin
				state_d = ((2*VW+2)'(dot_q) < cross_abs || dot_q[2*VW])
					? dfim_pkg::S_RD : dfim_pkg::S_DX;
			end
			dfim_pkg::S_DX: state_d = dfim_pkg::S_DY;
			dfim_pkg::S_DY: state_d = dfim_pkg::S_WGO;
			dfim_pkg::S_WGO: begin
				if (d2_q <= D2W'(1)) begin
					state_d = dfim_pkg::S_ACC1;
				end else begin
					div_num   = NUMW'(1) << 32;
					div_den   = DENW'(d2_q);
					div_start = 1'b1;
					state_d   = dfim_pkg::S_WDIV;
				end
			end
			dfim_pkg::S_WDIV: begin
				if (div_done) begin
					sq_start = 1'b1;
					state_d  = dfim_pkg::S_SQ;
				end
			end
			dfim_pkg::S_SQ: begin
				if (sq_done) begin
					state_d = dfim_pkg::S_ACC1;
				end
			end
			dfim_pkg::S_ACC1: state_d = dfim_pkg::S_ACC2;
			dfim_pkg::S_ACC2: state_d = dfim_pkg::S_ACC3;
			dfim_pkg::S_ACC3: state_d = dfim_pkg::S_RD;
			dfim_pkg::S_FCHK: begin
				if (sum_w_q < WSW'(dfim_pkg::MIN_WSUM)) begin
					state_d = dfim_pkg::S_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = dfim_pkg::S_FW;
				end
			end
			dfim_pkg::S_FW: begin
				if (div_done) begin
					div_num   = NUMW'(sum_wh_q);
					div_start = 1'b1;
					state_d   = dfim_pkg::S_FH;
				end
			end
			dfim_pkg::S_FH: begin
				if (div_done) begin
					state_d = dfim_pkg::S_AREA1;
				end
			end
			dfim_pkg::S_AREA1: state_d = dfim_pkg::S_AREA2;
			dfim_pkg::S_AREA2: begin
				state_d = (marea_q == '0) ? dfim_pkg::S_DONE : dfim_pkg::S_RGO;
			end
			dfim_pkg::S_RGO: begin
				div_num   = NUMW'({cur_q, 8'h00});
				div_den   = DENW'(marea_q);
				div_start = 1'b1;
				state_d   = dfim_pkg::S_RDIV;
			end
			dfim_pkg::S_RDIV: begin
				if (div_done) begin
					state_d = dfim_pkg::S_DONE;
				end
			end
			dfim_pkg::S_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = dfim_pkg::S_IDLE;
				end
			end
			default: state_d = dfim_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dfim_pkg::S_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				count_q <= count_q + CW'(1);
			end else if (acc && func == dfim_pkg::FUNC_CLEAR) begin
				count_q <= '0;
			end
			if (state_q == dfim_pkg::S_DONE && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (acc) begin
			qx_q      <= in_px;
			qy_q      <= in_py;
			qvx_q     <= in_vx;
			qvy_q     <= in_vy;
			qw_q      <= in_w;
			qh_q      <= in_h;
			use_dir_q <= (in_vx != '0) || (in_vy != '0);
			idx_q     <= '0;
			sum_w_q   <= '0;
			sum_ww_q  <= '0;
			sum_wh_q  <= '0;
			mw_q      <= '0;
			mh_q      <= '0;
			marea_q   <= '0;
			ratio_q   <= '0;
			status_q  <= (func == dfim_pkg::FUNC_ADD && !ram_we)
				? dfim_pkg::ST_FULL : dfim_pkg::ST_OK;
		end
		case (state_q)
			dfim_pkg::S_RDW: begin
				ent_q <= ram_rdata;
				if (use_dir_q && ram_rdata[PW+2*VW-1:PW] == '0) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			dfim_pkg::S_DOT1: p_q <= (2*VW+1)'(qvx_q * evx);
			dfim_pkg::S_DOT2: dot_q <= p_q + (2*VW+1)'(qvy_q * evy);
			dfim_pkg::S_CR1:  p_q <= (2*VW+1)'(qvx_q * evy);
			dfim_pkg::S_CR2: begin
				if ((2*VW+2)'(dot_q) < cross_abs || dot_q[2*VW]) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			dfim_pkg::S_DX: sq_q <= adx * adx;
			dfim_pkg::S_DY: d2_q <= D2W'(sq_q) + D2W'(ady * ady);
			dfim_pkg::S_WGO: begin
				if (d2_q <= D2W'(1)) begin
					wt_q <= dfim_pkg::WT_ONE;
				end
			end
			dfim_pkg::S_SQ: begin
				if (sq_done) begin
					wt_q <= dfim_pkg::WT_W'(sq_root);
				end
			end
			dfim_pkg::S_ACC1: begin
				sum_w_q <= sum_w_q + WSW'(wt_q);
				p2_q    <= wt_q * ew;
			end
			dfim_pkg::S_ACC2: begin
				sum_ww_q <= sum_ww_q + PSW'(p2_q);
				p2_q     <= wt_q * eh;
			end
			dfim_pkg::S_ACC3: begin
				sum_wh_q <= sum_wh_q + PSW'(p2_q);
				idx_q    <= idx_q + CW'(1);
			end
			dfim_pkg::S_FCHK: begin
				if (sum_w_q < WSW'(dfim_pkg::MIN_WSUM)) begin
					status_q <= dfim_pkg::ST_NO_SAMP;
				end
			end
			dfim_pkg::S_FW: begin
				if (div_done) begin
					mw_q <= div_quo[DMW-1:0];
				end
			end
			dfim_pkg::S_FH: begin
				if (div_done) begin
					mh_q <= div_quo[DMW-1:0];
				end
			end
			dfim_pkg::S_AREA1: marea_q <= mw_q * mh_q;
			dfim_pkg::S_AREA2: cur_q <= qw_q * qh_q;
			dfim_pkg::S_RDIV: begin
				if (div_done) begin
					ratio_q <= (div_quo > NUMW'(dfim_pkg::RATIO_MAX))
						? dfim_pkg::RATIO_MAX : div_quo[15:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	logic [63:0] m_data_q;
	logic [1:0]  m_user_q;

	always_ff @(posedge clk) begin
		if (state_q == dfim_pkg::S_DONE && (!m_valid_q || m_axis_tready)) begin
			m_data_q <= {ratio_q, marea_q, mh_q, mw_q};
			m_user_q <= status_q;
		end
	end

	assign s_axis_tready = state_q == dfim_pkg::S_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_nosamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == dfim_pkg::ST_NO_SAMP) |-> m_axis_tdata == '0)
		else $error("no-sample result carries data");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfim_pkg::S_WDIV) |-> !s_axis_tready)
		else $error("input ready during query walk");
`endif
endmodule

### rtl/dfim_ram.sv
`timescale 1ns / 1ps
module dfim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/dfim_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module dfim_div #(
	parameter int NUMW = 38,
	parameter int DENW = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic            busy,
	output logic            done,
	output logic [NUMW-1:0] quo
);
	localparam int CNTW = $clog2(NUMW + 1);

	logic            busy_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NUMW-1:0] num_q;
	logic [DENW-1:0] den_q, rem_q, rem_d;
	logic [DENW:0]   trial;
	logic            qbit;

	always_comb begin
		trial = {rem_q, num_q[NUMW-1]};
		qbit  = trial >= {1'b0, den_q};
		rem_d = qbit ? DENW'(trial - {1'b0, den_q}) : DENW'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_d;
			num_q <= {num_q[NUMW-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;
endmodule

### rtl/dfim_isqrt.sv
`timescale 1ns / 1ps
// digit-by-digit integer square root, one result bit per cycle
module dfim_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dfim_pkg::SQ_IN_W-1:0] x,
	output logic                         done,
	output logic [dfim_pkg::SQ_OUT_W-1:0] root
);
	localparam int W    = dfim_pkg::SQ_IN_W;
	localparam int CNTW = $clog2(dfim_pkg::SQ_STEPS + 1);

	logic            busy_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [W-1:0]    x_q, res_q, bit_q, trial;
	logic            ge;

	always_comb begin
		trial = res_q + bit_q;
		ge    = x_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(dfim_pkg::SQ_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			res_q <= '0;
			bit_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (ge) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[dfim_pkg::SQ_OUT_W-1:0];
endmodule
